FILE: rtl/sliding_window_stats_macros.svh
// assertion macros of the sliding window statistics port checker
`ifndef SLIDING_WINDOW_STATS_MACROS_SVH
`define SLIDING_WINDOW_STATS_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define SWST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define SWST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/swst_pkg.sv
// shared constants and types of the sliding window statistics block
package swst_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int RING_DEPTH_DEF = 256;
  localparam int SUM_BITS       = 24;
  localparam int LEN_BITS       = 9;
  localparam int LAG_BITS       = 8;
  localparam int WLEN_BITS      = 8;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DIV_CNT_BITS   = $clog2(SUM_BITS);

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(16);
  localparam logic                 EN_RESET   = 1'b1;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // register index is the word address bit
  localparam logic CFG_IDX_WLEN = 1'b0;
  localparam logic CFG_IDX_EN   = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [SUM_BITS-1:0]  dividend;
    logic [LEN_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [SUM_BITS-1:0]  quotient;
    logic [LEN_BITS-1:0]  remainder;
  } div_rsp_t;

endpackage

FILE: rtl/swst_if.sv
// valid/ready channel interfaces for input and result transactions
interface swst_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [swst_pkg::SAMPLE_BITS-1:0] sample;
  logic [swst_pkg::LAG_BITS-1:0]         lag;

  modport source (output valid, output mode, output sample, output lag, input ready);
  modport sink (input valid, input mode, input sample, input lag, output ready);
endinterface

interface swst_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [swst_pkg::SAMPLE_BITS-1:0] sample_out;
  logic signed [swst_pkg::SAMPLE_BITS-1:0] window_mean;
  logic signed [swst_pkg::SAMPLE_BITS-1:0] window_max;
  logic signed [swst_pkg::SAMPLE_BITS-1:0] window_min;
  logic [swst_pkg::SAMPLE_BITS-1:0]      peak_magnitude;

  modport source (output valid, output sample_out, output window_mean, output window_max,
                  output window_min, output peak_magnitude, input ready);
  modport sink (input valid, input sample_out, input window_mean, input window_max,
                input window_min, input peak_magnitude, output ready);
endinterface

FILE: rtl/swst_div.sv
// serial restoring divider, one quotient bit per cycle
module swst_div (
  input  logic               clk,
  input  logic               rst_n,
  input  swst_pkg::div_req_t req,
  output swst_pkg::div_rsp_t rsp
);

  localparam int DW = swst_pkg::SUM_BITS;
  localparam int RW = swst_pkg::LEN_BITS;

  logic                                busy_r;
  logic [swst_pkg::DIV_CNT_BITS-1:0]   cnt_r;
  logic [DW-1:0]                       quo_r;
  logic [RW-1:0]                       rem_r;
  logic [RW-1:0]                       dsr_r;
  logic [RW:0]                         trial;
  logic [RW:0]                         diff;
  logic                                ge;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == swst_pkg::DIV_CNT_BITS'(DW - 1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[RW-1:0] : trial[RW-1:0];
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: rtl/swst_ring.sv
// sample ring memory with registered read and a clearing pass after reset
module swst_ring #(
  parameter int RING_DEPTH = swst_pkg::RING_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  rd_en,
  input  logic [$clog2(RING_DEPTH)-1:0]         rd_addr,
  input  logic                                  wr_en,
  input  logic [$clog2(RING_DEPTH)-1:0]         wr_addr,
  input  logic signed [swst_pkg::SAMPLE_BITS-1:0] wr_data,
  output logic signed [swst_pkg::SAMPLE_BITS-1:0] rd_data,
  output logic                                  clr_busy
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SB = swst_pkg::SAMPLE_BITS;

  logic signed [SB-1:0] ring_mem [RING_DEPTH];
  logic signed [SB-1:0] rd_data_r;
  logic                 clr_busy_r;
  logic [AW-1:0]        clr_addr_r;
  logic                 we;
  logic [AW-1:0]        wa;
  logic signed [SB-1:0] wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(RING_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // the clearing pass owns the write port until it is done
  always_comb begin
    we = wr_en;
    wa = wr_addr;
    wd = wr_data;
    if (clr_busy_r) begin
      we = rst_n;
      wa = clr_addr_r;
      wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: rtl/sliding_window_stats.sv
// sliding window statistics: ring memory, running sum, mean, max, min and peak magnitude
// push, stats off: the result follows the ring read and write; push, stats on: it also waits
// for the 24-step serial divider and for a rescan of the window when an extreme is evicted
// read-back: the divider forms the ring index before the ring read; a lag outside the window
// skips both. a new transaction is taken the cycle after the result is registered. after
// reset a clearing pass zeroes the ring and no transaction is accepted; registers stay open
module sliding_window_stats #(
  parameter int RING_DEPTH = swst_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  swst_in_if.sink                             in_ch,
  swst_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swst_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [swst_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [swst_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int LW  = $clog2(RING_DEPTH + 1);
  localparam int SB  = swst_pkg::SAMPLE_BITS;
  localparam int SMW = swst_pkg::SUM_BITS;
  localparam int NW  = swst_pkg::LEN_BITS;
  localparam int WW  = swst_pkg::WLEN_BITS;
  localparam int DW  = swst_pkg::CFG_DATA_BITS;
  localparam int IW  = NW + 1;

  localparam logic [NW-1:0]        DEPTH_N  = NW'(RING_DEPTH);
  localparam logic [SMW-1:0]       POS_MAG  = SMW'(2 ** (SB - 1) - 1);
  localparam logic [SMW-1:0]       NEG_MAG  = SMW'(2 ** (SB - 1));
  localparam logic signed [SB-1:0] MEAN_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] MEAN_MIN = {1'b1, {(SB - 1){1'b0}}};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POLD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_RBDIV  = 3'd4;
  localparam logic [2:0] S_RBDATA = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // configuration
  logic [WW-1:0] wl_r, wl_nxt;
  logic          en_r, en_nxt;
  logic          cfg_wr;

  // control and statistics
  logic [2:0]            state_r, state_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic signed [SMW-1:0] sum_r, sum_nxt;
  logic signed [SB-1:0]  mean_r, mean_nxt;
  logic signed [SB-1:0]  max_r, max_nxt;
  logic signed [SB-1:0]  min_r, min_nxt;
  logic [AW-1:0]         maxp_r, maxp_nxt;
  logic [AW-1:0]         minp_r, minp_nxt;
  logic [SB-1:0]         mag_r, mag_nxt;
  logic                  rsc_max_r, rsc_max_nxt;
  logic                  rsc_min_r, rsc_min_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // working payload
  logic [AW-1:0]         pos_r, pos_nxt;
  logic signed [SB-1:0]  smp_r, smp_nxt;
  logic signed [SB-1:0]  res_r, res_nxt;
  logic [LW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         pidx_r, pidx_nxt;

  // result register
  logic signed [SB-1:0]  o_smp_r, o_mean_r, o_max_r, o_min_r;
  logic [SB-1:0]         o_mag_r;
  logic                  out_load;

  // datapath helpers
  logic [NW-1:0]         len_n;
  logic [LW-1:0]         len;
  logic [LW-1:0]         pos_full;
  logic [AW-1:0]         pos_c;
  logic [IW-1:0]         rb_idx;
  logic                  accept;
  logic signed [SMW-1:0] sum_c;
  logic [SMW-1:0]        q;
  logic signed [SB-1:0]  qlo;
  logic signed [SB:0]    mx, mn, amax, amin;

  // ring and divider hookup
  logic                  rd_en, wr_en, clr_busy;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic signed [SB-1:0]  wr_data, rd_data;
  swst_pkg::div_req_t    div_req;
  swst_pkg::div_rsp_t    div_rsp;

  swst_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  swst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // effective window length: zero means one, capped at the ring depth
  always_comb begin
    len_n = (wl_r == '0) ? NW'(1) : NW'(wl_r);
    if (len_n > DEPTH_N) begin
      len_n = DEPTH_N;
    end
    len      = len_n[LW-1:0];
    pos_full = LW'(wp_r) + LW'(1);
    pos_c    = (pos_full >= len) ? '0 : pos_full[AW-1:0];
    rb_idx   = IW'(wp_r) + IW'(len) - IW'(in_ch.lag);
  end

  assign accept = in_ch.valid && in_ch.ready;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    wl_nxt = wl_r;
    en_nxt = en_r;
    if (cfg_wr) begin
      case (paddr[2])
        swst_pkg::CFG_IDX_WLEN: wl_nxt = pwdata[WW-1:0];
        swst_pkg::CFG_IDX_EN:   en_nxt = pwdata[0];
        default:                wl_nxt = wl_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      swst_pkg::CFG_IDX_WLEN: prdata = DW'(wl_r);
      swst_pkg::CFG_IDX_EN:   prdata = DW'(en_r);
      default:                prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    maxp_nxt      = maxp_r;
    minp_nxt      = minp_r;
    mag_nxt       = mag_r;
    rsc_max_nxt   = rsc_max_r;
    rsc_min_nxt   = rsc_min_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    smp_nxt       = smp_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    pidx_nxt      = pidx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = pos_c;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = smp_r;
    sum_c         = sum_r - SMW'(rd_data) + SMW'(smp_r);
    q             = div_rsp.quotient;
    qlo           = q[SB-1:0];
    mx            = (SB + 1)'(max_r);
    mn            = (SB + 1)'(min_r);
    amax          = (mx < 0) ? -mx : mx;
    amin          = (mn < 0) ? -mn : mn;
    div_req.start    = 1'b0;
    div_req.dividend = SMW'(rb_idx);
    div_req.divisor  = len_n;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.mode == swst_pkg::MODE_PUSH) begin
            rd_en     = 1'b1;
            pos_nxt   = pos_c;
            smp_nxt   = in_ch.sample;
            state_nxt = S_POLD;
          end else if (NW'(in_ch.lag) < len_n) begin
            // ring index is (write position + length - lag) mod length
            div_req.start = 1'b1;
            state_nxt     = S_RBDIV;
          end else begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_POLD: begin
        wr_en   = 1'b1;
        wp_nxt  = pos_r;
        res_nxt = rd_data;
        if (en_r) begin
          sum_nxt          = sum_c;
          div_req.start    = 1'b1;
          div_req.dividend = sum_c[SMW-1] ? SMW'(-sum_c) : SMW'(sum_c);
          rsc_max_nxt      = (maxp_r == pos_r);
          rsc_min_nxt      = (minp_r == pos_r);
          if (maxp_r != pos_r && smp_r > max_r) begin
            max_nxt  = smp_r;
            maxp_nxt = pos_r;
          end
          if (minp_r != pos_r && smp_r < min_r) begin
            min_nxt  = smp_r;
            minp_nxt = pos_r;
          end
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          state_nxt = (maxp_r == pos_r || minp_r == pos_r) ? S_SCAN : S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SCAN: begin
        // reads stream one per cycle, each compared in the cycle after its read
        pend_nxt = 1'b0;
        if (pend_r) begin
          if (rsc_max_r && (pidx_r == '0 || rd_data > max_r)) begin
            max_nxt  = rd_data;
            maxp_nxt = pidx_r;
          end
          if (rsc_min_r && (pidx_r == '0 || rd_data < min_r)) begin
            min_nxt  = rd_data;
            minp_nxt = pidx_r;
          end
        end
        if (cnt_r < len) begin
          rd_en    = 1'b1;
          rd_addr  = cnt_r[AW-1:0];
          pidx_nxt = cnt_r[AW-1:0];
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_rsp.busy) begin
          if (sum_r[SMW-1]) begin
            mean_nxt = (q > NEG_MAG) ? MEAN_MIN : -qlo;
          end else begin
            mean_nxt = (q > POS_MAG) ? MEAN_MAX : qlo;
          end
          mag_nxt   = (amax > amin) ? amax[SB-1:0] : amin[SB-1:0];
          state_nxt = S_OUT;
        end
      end
      S_RBDIV: begin
        if (!div_rsp.busy) begin
          rd_en     = 1'b1;
          rd_addr   = div_rsp.remainder[AW-1:0];
          state_nxt = S_RBDATA;
        end
      end
      S_RBDATA: begin
        res_nxt   = rd_data;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= swst_pkg::WLEN_RESET;
      en_r        <= swst_pkg::EN_RESET;
      state_r     <= S_IDLE;
      wp_r        <= '0;
      sum_r       <= '0;
      mean_r      <= '0;
      max_r       <= '0;
      min_r       <= '0;
      maxp_r      <= '0;
      minp_r      <= '0;
      mag_r       <= '0;
      rsc_max_r   <= 1'b0;
      rsc_min_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wl_r        <= wl_nxt;
      en_r        <= en_nxt;
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      mean_r      <= mean_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      maxp_r      <= maxp_nxt;
      minp_r      <= minp_nxt;
      mag_r       <= mag_nxt;
      rsc_max_r   <= rsc_max_nxt;
      rsc_min_r   <= rsc_min_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    smp_r  <= smp_nxt;
    res_r  <= res_nxt;
    cnt_r  <= cnt_nxt;
    pidx_r <= pidx_nxt;
    if (out_load) begin
      o_smp_r  <= res_r;
      o_mean_r <= mean_r;
      o_max_r  <= max_r;
      o_min_r  <= min_r;
      o_mag_r  <= mag_r;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE) && !clr_busy;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample_out     = o_smp_r;
  assign out_ch.window_mean    = o_mean_r;
  assign out_ch.window_max     = o_max_r;
  assign out_ch.window_min     = o_min_r;
  assign out_ch.peak_magnitude = o_mag_r;

endmodule

FILE: rtl/swst_checker.sv
// port-level checks of the sliding window statistics block, bound to the top level
`include "sliding_window_stats_macros.svh"

module swst_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [swst_pkg::SAMPLE_BITS-1:0] out_sample_out,
  input logic signed [swst_pkg::SAMPLE_BITS-1:0] out_window_mean,
  input logic signed [swst_pkg::SAMPLE_BITS-1:0] out_window_max,
  input logic signed [swst_pkg::SAMPLE_BITS-1:0] out_window_min,
  input logic [swst_pkg::SAMPLE_BITS-1:0]      out_peak_magnitude,
  input logic                                  psel,
  input logic [swst_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input logic [swst_pkg::CFG_DATA_BITS-1:0]    prdata
);

  // the ring clearing pass keeps the input closed right after reset
  `SWST_ASSERT_IMP(a_clear_after_reset, !$past(rst_n), !in_ready, "transaction open during ring clear")

  // one item at a time: an accepted transaction closes the input next cycle
  `SWST_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open while item in flight")

  `SWST_ASSERT_NXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_sample_out) && $stable(out_window_mean) && $stable(out_window_max) && $stable(out_window_min) && $stable(out_peak_magnitude), "stalled result changed")

  // window length read-back carries only its 8 register bits
  `SWST_ASSERT_IMP(a_wlen_readback, psel && (paddr[2] == swst_pkg::CFG_IDX_WLEN), prdata[swst_pkg::CFG_DATA_BITS-1:swst_pkg::WLEN_BITS] == '0, "window length read-back has high bits set")

endmodule

bind sliding_window_stats swst_checker u_swst_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_sample_out     (out_ch.sample_out),
  .out_window_mean    (out_ch.window_mean),
  .out_window_max     (out_ch.window_max),
  .out_window_min     (out_ch.window_min),
  .out_peak_magnitude (out_ch.peak_magnitude),
  .psel               (psel),
  .paddr              (paddr),
  .prdata             (prdata)
);

FILE: sim/sliding_window_stats_checker.sv
`timescale 1ns / 100ps
// watches the channels and register port, predicts each result and compares it
module sliding_window_stats_checker
  import swst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  swst_in_if                       in_mon,
  swst_out_if                      out_mon,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output int                       fail_count,
  output int                       pending,
  output int                       checked_count
);

  localparam int Q88_HI = 32767;
  localparam int Q88_LO = -32768;

  typedef logic signed [SAMPLE_BITS-1:0] q88_t;

  typedef struct packed {
    q88_t                   sample_out;
    q88_t                   mean;
    q88_t                   max;
    q88_t                   min;
    logic [SAMPLE_BITS-1:0] peak;
  } window_result_t;

  q88_t                       ring [RING_DEPTH_DEF];
  logic [WLEN_BITS-1:0]       wr_pos;
  logic signed [SUM_BITS-1:0] acc_sum;
  q88_t                       mean_q;
  q88_t                       max_q;
  q88_t                       min_q;
  logic [WLEN_BITS-1:0]       max_at;
  logic [WLEN_BITS-1:0]       min_at;
  logic [SAMPLE_BITS:0]       peak_q;
  logic [WLEN_BITS-1:0]       wlen_reg;
  logic                       en_reg;
  window_result_t             expected_results [$];

  // advances the model by one transaction and returns the result it should produce
  function automatic window_result_t predict_window(logic mode, q88_t s,
                                                    logic [LAG_BITS-1:0] lag);
    window_result_t r;
    int len;
    int pos;
    int quot;
    int amax;
    int amin;
    q88_t evicted;
    len = (wlen_reg == '0) ? 1 : int'(wlen_reg);
    if (mode == MODE_PUSH) begin
      pos = int'(wr_pos) + 1;
      // a stale position after the window shrinks wraps as well
      if (pos >= len) pos = 0;
      wr_pos = pos[WLEN_BITS-1:0];
      evicted = ring[pos];
      ring[pos] = s;
      r.sample_out = evicted;
      if (en_reg) begin
        acc_sum = acc_sum - evicted + s;
        quot = int'(acc_sum) / len;
        mean_q = (quot > Q88_HI) ? q88_t'(Q88_HI) :
                 (quot < Q88_LO) ? q88_t'(Q88_LO) : q88_t'(quot);
        if (int'(max_at) == pos) begin
          max_q = ring[0];
          max_at = '0;
          for (int i = 1; i < len; i++) begin
            if (ring[i] > max_q) begin
              max_q = ring[i];
              max_at = i[WLEN_BITS-1:0];
            end
          end
        end else if (s > max_q) begin
          max_q = s;
          max_at = pos[WLEN_BITS-1:0];
        end
        if (int'(min_at) == pos) begin
          min_q = ring[0];
          min_at = '0;
          for (int i = 1; i < len; i++) begin
            if (ring[i] < min_q) begin
              min_q = ring[i];
              min_at = i[WLEN_BITS-1:0];
            end
          end
        end else if (s < min_q) begin
          min_q = s;
          min_at = pos[WLEN_BITS-1:0];
        end
        amax = (max_q < 0) ? -int'(max_q) : int'(max_q);
        amin = (min_q < 0) ? -int'(min_q) : int'(min_q);
        peak_q = (amax > amin) ? amax[SAMPLE_BITS:0] : amin[SAMPLE_BITS:0];
      end
    end else begin
      r.sample_out = (int'(lag) < len) ? ring[(int'(wr_pos) + len - int'(lag)) % len] : '0;
    end
    r.mean = mean_q;
    r.max  = max_q;
    r.min  = min_q;
    r.peak = peak_q[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function automatic int field_differs(string name, int want, int got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    window_result_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH_DEF; i++) ring[i] = '0;
      wr_pos   = '0;
      acc_sum  = '0;
      mean_q   = '0;
      max_q    = '0;
      min_q    = '0;
      max_at   = '0;
      min_at   = '0;
      peak_q   = '0;
      wlen_reg = WLEN_RESET;
      en_reg   = EN_RESET;
      expected_results.delete();
      fail_count    <= 0;
      checked_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[CFG_ADDR_BITS-1] == CFG_IDX_EN) en_reg = pwdata[0];
        else wlen_reg = pwdata[WLEN_BITS-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        checked_count <= checked_count + 1;
        if (expected_results.size() == 0) begin
          $error("result transaction arrived with nothing expected");
          bad = 1;
        end else begin
          want = expected_results.pop_front();
          bad = field_differs("sample_out", int'(want.sample_out), int'(out_mon.sample_out))
              + field_differs("window_mean", int'(want.mean), int'(out_mon.window_mean))
              + field_differs("window_max", int'(want.max), int'(out_mon.window_max))
              + field_differs("window_min", int'(want.min), int'(out_mon.window_min))
              + field_differs("peak_magnitude", int'(want.peak),
                              int'(out_mon.peak_magnitude));
        end
        fail_count <= fail_count + bad;
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_window(in_mon.mode, in_mon.sample, in_mon.lag));
    end
    pending <= expected_results.size();
  end

endmodule

FILE: sim/sliding_window_stats_tb.sv
`timescale 1ns / 100ps
// top of the window statistics testbench: clock, reset, register writes and stimulus
module sliding_window_stats_tb;
  import swst_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int ITEM_TARGET   = 1150;
  localparam int Q88_HI        = 32767;
  localparam int Q88_LO        = -32768;
  localparam logic [CFG_ADDR_BITS-1:0] WLEN_ADDR = {CFG_IDX_WLEN, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] EN_ADDR   = {CFG_IDX_EN, 2'b00};

  typedef logic signed [SAMPLE_BITS-1:0] q88_t;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  int fail_count;
  int pending;
  int checked_count;
  int cycles;
  int sent;
  int pushes;
  int reads;
  int phases;
  bit no_gaps;

  swst_in_if  in_ch ();
  swst_out_if out_ch ();

  sliding_window_stats uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sliding_window_stats_checker stats_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results still expected", cycles, pending);
      $display("sliding_window_stats: mismatch");
      $finish;
    end
  end

  // result side: random stall before each transaction, none while no_gaps is set
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(10, 0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // leaves psel high so a following write can start in the same cycle
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic send_item(input logic mode, input q88_t s, input logic [LAG_BITS-1:0] lag);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(10, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.sample <= s;
    in_ch.lag    <= lag;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    sent++;
    if (mode == MODE_PUSH) pushes++;
    else reads++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_item(input int lo, input int hi, input int read_pct, input int len);
    q88_t                s;
    logic [LAG_BITS-1:0] lag;
    logic                mode;
    case ($urandom_range(15, 0))
      0:       s = q88_t'(hi);
      1:       s = q88_t'(lo);
      default: s = q88_t'(lo + int'($urandom_range(hi - lo, 0)));
    endcase
    // half of the lags are drawn inside the window, the rest from the full lag range
    lag  = $urandom_range(1, 0) ? LAG_BITS'($urandom_range(len - 1, 0))
                                : LAG_BITS'($urandom_range(255, 0));
    mode = (int'($urandom_range(99, 0)) < read_pct) ? MODE_READ : MODE_PUSH;
    send_item(mode, s, lag);
  endtask

  task automatic run_phase(input int wlen, input logic en, input int n, input int lo,
                           input int hi, input int read_pct, input bit quiet);
    drain_results();
    write_reg(WLEN_ADDR, CFG_DATA_BITS'(wlen));
    write_reg(EN_ADDR, CFG_DATA_BITS'(en));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    no_gaps = quiet;
    phases++;
    repeat (n) random_item(lo, hi, read_pct, (wlen == 0) ? 1 : wlen);
  endtask

  initial begin
    int wl;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_PUSH;
    in_ch.sample = '0;
    in_ch.lag    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    no_gaps      = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: sample extremes, then read-backs in and out of the window
    send_item(MODE_PUSH, q88_t'(Q88_HI), '0);
    send_item(MODE_PUSH, q88_t'(Q88_LO), '1);
    send_item(MODE_PUSH, '0, '0);
    send_item(MODE_PUSH, q88_t'(1), '0);
    send_item(MODE_PUSH, q88_t'(-1), '0);
    send_item(MODE_READ, '0, LAG_BITS'(0));
    send_item(MODE_READ, '0, LAG_BITS'(1));
    send_item(MODE_READ, '0, LAG_BITS'(15));
    send_item(MODE_READ, '1, LAG_BITS'(16));
    send_item(MODE_READ, '0, LAG_BITS'(255));
    // wrap the ring so the slots holding the max and then the min get evicted
    for (int k = 0; k < 13; k++) send_item(MODE_PUSH, q88_t'(k * 37 - 200), '0);

    run_phase(0, 1'b1, 30, Q88_LO, Q88_HI, 30, 1'b0);
    run_phase(1, 1'b1, 30, Q88_LO, Q88_HI, 30, 1'b0);
    run_phase(2, 1'b0, 30, Q88_LO, Q88_HI, 30, 1'b0);
    run_phase(2, 1'b1, 30, Q88_LO, Q88_HI, 30, 1'b0);
    run_phase(5, 1'b1, 60, Q88_LO, Q88_HI, 30, 1'b1);
    // fill the largest window with high values, swap in low ones unseen, then
    // re-enable so the running sum wraps
    run_phase(255, 1'b1, 290, 30000, Q88_HI, 10, 1'b0);
    run_phase(255, 1'b0, 50, Q88_LO, -30000, 10, 1'b0);
    run_phase(255, 1'b1, 50, 30000, Q88_HI, 10, 1'b0);
    // shrink with a write position far beyond the new length
    run_phase(7, 1'b1, 30, Q88_LO, Q88_HI, 30, 1'b1);
    // length one with a huge sum drives the mean into saturation
    run_phase(1, 1'b1, 20, Q88_LO, Q88_HI, 30, 1'b0);

    while (sent < ITEM_TARGET) begin
      wl = ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(32, 1);
      run_phase(wl, ($urandom_range(4, 0) != 0), $urandom_range(60, 20), Q88_LO, Q88_HI, 30,
                ($urandom_range(3, 0) == 0));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d transactions (%0d pushes, %0d read-backs) over %0d register settings",
             sent, pushes, reads, phases + 1);
    $display("%0d results compared field by field, %0d failures", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("sliding_window_stats: match");
    end else begin
      $display("sliding_window_stats: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/swst_pkg.sv
rtl/swst_if.sv
rtl/swst_div.sv
rtl/swst_ring.sv
rtl/sliding_window_stats.sv
rtl/swst_checker.sv
sim/sliding_window_stats_checker.sv
sim/sliding_window_stats_tb.sv
